@@ design/ryuv_pkg.sv @@
package ryuv_pkg;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_Y    = 2'd1,
    MODE_U    = 2'd2,
    MODE_V    = 2'd3
  } color_mode_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Accumulator width: every weighted sum plus its offset stays below 2**24,
  // and one extra bit carries the sign of the intermediate terms.
  localparam int unsigned AccW = 25;
  localparam int unsigned FracW = 16;

  typedef logic signed [AccW-1:0] acc_t;

  // Q0.16 coefficients, rounded to nearest.
  localparam acc_t CoefYR = 25'sd16843;
  localparam acc_t CoefYG = 25'sd33030;
  localparam acc_t CoefYB = 25'sd6423;
  localparam acc_t CoefUR = -25'sd9699;
  localparam acc_t CoefUG = -25'sd19071;
  localparam acc_t CoefUB = 25'sd28770;
  localparam acc_t CoefVR = 25'sd28770;
  localparam acc_t CoefVG = -25'sd24117;
  localparam acc_t CoefVB = -25'sd4653;

  localparam acc_t OffsetY  = acc_t'(16) <<< FracW;
  localparam acc_t OffsetUV = acc_t'(128) <<< FracW;

  // Floor shift by the fraction width, then saturate to 0..255.
  function automatic logic [7:0] clamp_component(input acc_t acc);
    acc_t       level;
    logic [7:0] res;
    level = acc >>> FracW;
    if (acc[AccW-1]) begin
      res = 8'd0;
    end else if (level > acc_t'(255)) begin
      res = 8'd255;
    end else begin
      res = level[7:0];
    end
    return res;
  endfunction

endpackage

@@ design/ryuv_pixel_in_if.sv @@
interface ryuv_pixel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

@@ design/ryuv_pixel_out_if.sv @@
interface ryuv_pixel_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, output out_red, output out_green, output out_blue, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue, output ready);
endinterface

@@ design/ryuv_cfg_if.sv @@
interface ryuv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] color_mode;

  modport source (output valid, output color_mode, input ready);
  modport sink   (input valid, input color_mode, output ready);
endinterface

@@ design/rgb_to_yuv_channel_view_unit.sv @@
// RGB to YUV channel viewer.
// Pixels enter on in_i and leave on out_o; both are valid/ready channels and
// a transfer happens on a clock edge with valid and ready high. cfg_i writes
// the two-bit color mode (pass-through, Y, U or V) and is always ready; it
// should only be written while no pixel is in flight.
// Each pixel is captured in an input register, converted by one layer of
// constant multiplies, a sum and a clamp, and lands in the output register.
// out_o.valid rises once the pixel has moved from the input register into the
// output register, and the block takes one pixel every cycle as long as the
// sink keeps up.
// When the sink stalls, the output register holds its pixel, the input
// register fills behind it, and in_i.ready drops once both are occupied;
// nothing is dropped or repeated. Throughput is set by the two-stage
// register chain with no internal iteration.
// Reset empties both stages and sets the mode to pass-through.
module rgb_to_yuv_channel_view_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ryuv_pixel_in_if.sink     in_i,
  ryuv_pixel_out_if.source  out_o,
  ryuv_cfg_if.sink          cfg_i
);

  ryuv_pkg::color_mode_e mode_q;
  logic                  s1_valid_q;
  ryuv_pkg::pixel_t      s1_pix_q;
  logic                  s2_valid_q;
  ryuv_pkg::pixel_t      s2_pix_q;
  ryuv_pkg::pixel_t      s2_pix_d;
  logic                  s2_load;
  logic                  s1_load;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ryuv_pkg::MODE_PASS;
    end else if (cfg_i.valid) begin
      mode_q <= ryuv_pkg::color_mode_e'(cfg_i.color_mode);
    end
  end

  // The output stage accepts whenever it is empty or its pixel is leaving.
  assign s2_load    = !s2_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_load;
  assign s1_load    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_pix_q <= '{red: in_i.in_red, green: in_i.in_green, blue: in_i.in_blue};
    end
    if (s2_load && s1_valid_q) begin
      s2_pix_q <= s2_pix_d;
    end
  end

  ryuv_convert u_convert (
    .pix_i  (s1_pix_q),
    .mode_i (mode_q),
    .pix_o  (s2_pix_d)
  );

  assign out_o.valid     = s2_valid_q;
  assign out_o.out_red   = s2_pix_q.red;
  assign out_o.out_green = s2_pix_q.green;
  assign out_o.out_blue  = s2_pix_q.blue;

endmodule

@@ design/ryuv_convert.sv @@
module ryuv_convert (
  input  ryuv_pkg::pixel_t      pix_i,
  input  ryuv_pkg::color_mode_e mode_i,
  output ryuv_pkg::pixel_t      pix_o
);

  ryuv_pkg::acc_t r_ext;
  ryuv_pkg::acc_t g_ext;
  ryuv_pkg::acc_t b_ext;
  ryuv_pkg::acc_t acc_y;
  ryuv_pkg::acc_t acc_u;
  ryuv_pkg::acc_t acc_v;
  logic [7:0]     pick;

  assign r_ext = ryuv_pkg::acc_t'({17'd0, pix_i.red});
  assign g_ext = ryuv_pkg::acc_t'({17'd0, pix_i.green});
  assign b_ext = ryuv_pkg::acc_t'({17'd0, pix_i.blue});

  // Products are exact in the accumulator width, so wrapping never occurs.
  assign acc_y = r_ext * ryuv_pkg::CoefYR + g_ext * ryuv_pkg::CoefYG
               + b_ext * ryuv_pkg::CoefYB + ryuv_pkg::OffsetY;
  assign acc_u = r_ext * ryuv_pkg::CoefUR + g_ext * ryuv_pkg::CoefUG
               + b_ext * ryuv_pkg::CoefUB + ryuv_pkg::OffsetUV;
  assign acc_v = r_ext * ryuv_pkg::CoefVR + g_ext * ryuv_pkg::CoefVG
               + b_ext * ryuv_pkg::CoefVB + ryuv_pkg::OffsetUV;

  always_comb begin
    case (mode_i)
      ryuv_pkg::MODE_Y: pick = ryuv_pkg::clamp_component(acc_y);
      ryuv_pkg::MODE_U: pick = ryuv_pkg::clamp_component(acc_u);
      ryuv_pkg::MODE_V: pick = ryuv_pkg::clamp_component(acc_v);
      default:          pick = 8'd0;
    endcase
    if (mode_i == ryuv_pkg::MODE_PASS) begin
      pix_o = pix_i;
    end else begin
      pix_o = '{red: pick, green: pick, blue: pick};
    end
  end

endmodule
